>>> hdl/clcd_pkg.sv
// Package: command codes, field widths and constants for the character LCD sequencer.
`default_nettype none
package clcd_pkg;
  localparam int unsigned MAX_CLEAR_COUNT = 16;
  localparam int unsigned MAX_RESULTS = 36;

  localparam logic [3:0] CMD_INIT    = 4'd0;
  localparam logic [3:0] CMD_RAW     = 4'd1;
  localparam logic [3:0] CMD_CHAR    = 4'd2;
  localparam logic [3:0] CMD_CLEAR   = 4'd3;
  localparam logic [3:0] CMD_GOTO    = 4'd4;
  localparam logic [3:0] CMD_CGRAM   = 4'd5;
  localparam logic [3:0] CMD_HEX     = 4'd6;
  localparam logic [3:0] CMD_DEC4    = 4'd7;
  localparam logic [3:0] CMD_BIN     = 4'd8;
  localparam logic [3:0] CMD_SIGNED  = 4'd9;
  localparam logic [3:0] CMD_GOTOCLR = 4'd10;

  localparam logic [7:0] LCD_SET_DDRAM   = 8'b10000000;
  localparam logic [7:0] LCD_LINE1_BASE  = 8'h40;
  localparam logic [7:0] LCD_SET_CGRAM   = 8'b01000000;
  localparam logic [7:0] LCD_FUNC_8BIT   = 8'b00110000;
  localparam logic [7:0] LCD_DISP_CUR    = 8'b00001110;
  localparam logic [7:0] LCD_CLR_DISPLAY = 8'b00000001;
  localparam logic [7:0] LCD_ENTRY       = 8'b00000110;
  localparam logic [7:0] LCD_FUNC_4BIT   = 8'b00100010;
  localparam logic [7:0] LCD_DISP_ON     = 8'b00001100;
  localparam logic [5:0] INIT_WAIT_MS    = 6'd50;

  // ceil(2^35 / 10): floor(x * DIV10_RECIP / 2^35) is x / 10 for any 32-bit x
  localparam logic [31:0] DIV10_RECIP    = 32'hCCCCCCCD;

  // one byte transfer request from the sequencer to the strobe stage
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic [5:0] pre;
    logic [1:0] after;
    logic       single;   // one raw strobe, even in 4-bit mode
    logic       last;
  } byte_req_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction
endpackage
`default_nettype wire

>>> hdl/clcd_strobe.sv
// Strobe stage: splits a byte request into one or two bus strobes with an output register.
`default_nettype none
module clcd_strobe (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                bus_mode,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire clcd_pkg::byte_req_t req,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     reg_select,
  output logic [7:0]               bus_value,
  output logic [5:0]               wait_before_ms,
  output logic [1:0]               wait_after_ms,
  output logic                     last
);
  import clcd_pkg::*;

  byte_req_t held;
  logic      second;
  logic      busy;

  assign req_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      second <= 1'b0;
      out_valid <= 1'b0;
    end else if (!busy || (out_valid && out_ready)) begin
      if (busy && second) begin
        second <= 1'b0;
        out_valid <= 1'b1;
        bus_value <= {held.data[3:0], 4'd0};
        wait_before_ms <= 6'd0;
        wait_after_ms <= held.after;
        last <= held.last;
        reg_select <= held.rs;
      end else if (req_valid && !busy) begin
        held <= req;
        busy <= 1'b1;
        out_valid <= 1'b1;
        reg_select <= req.rs;
        wait_before_ms <= req.pre;
        if (bus_mode && !req.single) begin
          second <= 1'b1;
          bus_value <= {req.data[7:4], 4'd0};
          wait_after_ms <= 2'd0;
          last <= 1'b0;
        end else begin
          bus_value <= req.data;
          wait_after_ms <= req.after;
          last <= req.last;
        end
      end else begin
        busy <= 1'b0;
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/char_lcd_command_sequencer.sv
// Top level: character LCD command sequencer with a shared digit unit.
// Usage: an input item (cmd, value, line, column, clear_count) is taken on
// valid & ready. The block then emits one item per LCD enable strobe on the
// output channel (reg_select, bus_value, waits, last); last marks the final
// strobe of the command. Commands that emit nothing finish silently.
// ready is low while a command is being worked; one command at a time.
// Each byte request is registered and passes through the strobe stage's
// output register; the sequencer issues its next byte request only when
// the strobe stage is free. Decimal commands first split the number into
// digits on one shared reciprocal multiplier, a multiply phase and then a
// remainder phase per digit. A command that emits nothing returns ready
// after one pass through the emit state; the longest command is goto-clear
// with sixteen spaces in 4-bit mode. A receiver stall holds the output
// register and holds the sequencer at its next byte.
// bus_mode is written by cfg_we/cfg_data and resets to 4-bit mode (1).
// Reset empties all stages and drops any command in work.
`default_nettype none
module char_lcd_command_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  cmd,
  input  wire logic signed [31:0] value,
  input  wire logic [1:0]  line,
  input  wire logic [5:0]  column,
  input  wire logic [4:0]  clear_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             reg_select,
  output logic [7:0]       bus_value,
  output logic [5:0]       wait_before_ms,
  output logic [1:0]       wait_after_ms,
  output logic             last
);
  import clcd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EMIT = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_DIGS = 3'd4;

  logic        bus_mode;
  logic [2:0]  state;
  logic [3:0]  op;
  logic [31:0] val;
  logic [7:0]  gaddr;
  logic        gok;
  logic [4:0]  cnt;
  logic [5:0]  idx;
  logic [5:0]  nsteps;
  logic [31:0] quo;
  logic        phase;
  logic [28:0] prod;
  logic [3:0]  digs [10];
  logic [3:0]  ndig;
  logic [3:0]  dpos;

  byte_req_t   req;
  logic        req_valid;
  logic        req_ready;
  logic        have;
  logic        issue;

  logic [63:0] mul_full;
  logic [3:0]  q10_lo;
  logic [7:0]  b;
  logic [15:0] n16;
  logic [3:0]  lead;

  assign b = val[7:0];
  assign n16 = val[15:0];
  assign in_ready = (state == S_IDLE);
  assign nsteps = {1'b0, cnt} + (gok ? 6'd2 : 6'd0);

  // shared reciprocal multiply: quotient by ten, then remainder from its low bits
  assign mul_full = 64'(quo) * 64'(DIV10_RECIP);
  assign q10_lo = {prod[0], 3'b000} + {prod[2:0], 1'b0};

  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) lead = 4'(i);
    end
  end

  // byte table per command and index
  always_comb begin
    req = '0;
    have = 1'b0;
    req.after = 2'd1;
    case (op)
      CMD_INIT: begin
        have = 1'b1;
        if (!bus_mode) begin
          case (idx)
            6'd0: begin req.data = LCD_FUNC_8BIT; req.pre = INIT_WAIT_MS; end
            6'd1: req.data = LCD_DISP_CUR;
            6'd2: begin req.data = LCD_CLR_DISPLAY; req.after = 2'd2; end
            default: begin req.data = LCD_ENTRY; req.last = 1'b1; end
          endcase
        end else begin
          case (idx)
            6'd0: begin req.data = LCD_FUNC_4BIT; req.pre = INIT_WAIT_MS; end
            6'd1: begin
              req.data = LCD_SET_DDRAM | {LCD_FUNC_4BIT[3:0], 4'd0} & 8'h30;
              req.single = 1'b1;
            end
            6'd2: req.data = LCD_DISP_ON;
            6'd3: begin req.data = LCD_CLR_DISPLAY; req.after = 2'd2; end
            default: begin req.data = LCD_ENTRY; req.last = 1'b1; end
          endcase
        end
      end
      CMD_RAW: begin have = 1'b1; req.data = b; req.last = 1'b1; end
      CMD_CHAR: begin have = 1'b1; req.rs = 1'b1; req.data = b; req.last = 1'b1; end
      CMD_CLEAR: begin
        have = 1'b1; req.data = LCD_CLR_DISPLAY; req.after = 2'd2; req.last = 1'b1;
      end
      CMD_GOTO: begin have = gok; req.data = LCD_SET_DDRAM | gaddr; req.last = 1'b1; end
      CMD_CGRAM: begin
        have = 1'b1; req.data = LCD_SET_CGRAM | {2'd0, val[2:0], 3'd0}; req.last = 1'b1;
      end
      CMD_HEX: begin
        have = 1'b1; req.rs = 1'b1;
        case (idx)
          6'd0: req.data = 8'h30;
          6'd1: req.data = 8'h78;
          6'd2: req.data = hex_char(b[7:4]);
          default: begin req.data = hex_char(b[3:0]); req.last = 1'b1; end
        endcase
      end
      CMD_BIN: begin
        have = 1'b1; req.rs = 1'b1;
        req.data = 8'h30 + {7'd0, b[3'(lead - idx[3:0])]};
        req.last = (idx[3:0] == lead);
      end
      CMD_GOTOCLR: begin
        req.rs = 1'b1;
        req.data = 8'h20;
        have = 1'b1;
        if (gok && idx == 6'd0) begin
          req.rs = 1'b0; req.data = LCD_SET_DDRAM | gaddr;
          req.last = 1'b0;
        end else if (gok && idx == nsteps - 6'd1) begin
          req.rs = 1'b0; req.data = LCD_SET_DDRAM | gaddr; req.last = 1'b1;
        end else begin
          req.last = (idx == nsteps - 6'd1);
        end
      end
      default: have = 1'b0;
    endcase
  end

  always_comb begin
    issue = 1'b0;
    if (!req_valid && req_ready) begin
      case (state)
        S_EMIT: issue = have && !(op == CMD_GOTOCLR && !gok && cnt == 5'd0);
        S_SIGN: issue = 1'b1;
        S_DIGS: issue = 1'b1;
        default: issue = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode <= 1'b1;
    end else if (cfg_we) begin
      bus_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= cmd;
            val <= value;
            gok <= (line == 2'd0) || (line == 2'd1);
            gaddr <= (line == 2'd1) ? (LCD_LINE1_BASE + {2'd0, column}) : {2'd0, column};
            cnt <= (clear_count > 5'(MAX_CLEAR_COUNT)) ? 5'(MAX_CLEAR_COUNT)
                                                       : clear_count;
            idx <= 6'd0;
            if (cmd == CMD_SIGNED) begin
              quo <= value[31] ? (32'd0 - value) : value;
              phase <= 1'b0; ndig <= 4'd0;
              state <= S_DIV;
            end else if (cmd == CMD_DEC4) begin
              quo <= {16'd0, value[15:0]};
              phase <= 1'b0; ndig <= 4'd0;
              state <= S_DIV;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!have || (op == CMD_GOTOCLR && !gok && cnt == 5'd0)) begin
            state <= S_IDLE;
          end else if (issue) begin
            idx <= idx + 6'd1;
            if (req.last) state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (!phase) begin
            prod <= mul_full[63:35];
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            quo <= {3'd0, prod};
            digs[ndig] <= quo[3:0] - q10_lo;
            ndig <= ndig + 4'd1;
            if ((op == CMD_DEC4 && ndig == 4'd3) ||
                (op == CMD_SIGNED && prod == 29'd0) || ndig == 4'd9) begin
              dpos <= ndig;
              state <= (op == CMD_SIGNED && val[31]) ? S_SIGN : S_DIGS;
            end
          end
        end
        S_SIGN: begin
          if (issue) begin
            state <= S_DIGS;
          end
        end
        default: begin
          if (issue) begin
            dpos <= dpos - 4'd1;
            if (dpos == 4'd0) state <= S_IDLE;
          end
        end
      endcase
    end
  end

  byte_req_t sreq;
  always_ff @(posedge clk) begin
    if (state == S_SIGN) begin
      sreq <= '{rs: 1'b1, data: 8'h2D, pre: 6'd0, after: 2'd1, single: 1'b0,
                last: 1'b0};
    end else if (state == S_DIGS) begin
      sreq <= '{rs: 1'b1, data: 8'h30 + {4'd0, digs[dpos]}, pre: 6'd0,
                after: 2'd1, single: 1'b0, last: dpos == 4'd0};
    end else begin
      sreq <= req;
    end
  end

  clcd_strobe u_strobe (
    .clk, .rst, .bus_mode,
    .req_valid, .req_ready, .req(sreq),
    .out_valid, .out_ready, .reg_select, .bus_value,
    .wait_before_ms, .wait_after_ms, .last
  );
endmodule
`default_nettype wire

>>> hdl/clcd_checker.sv
// Checker: port-level properties of the sequencer, bound to the top level.
`default_nettype none
module clcd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] bus_value,
  input wire logic [1:0] wait_after_ms,
  input wire logic       last
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bus_value) && $stable(last))
    else $error("output changed under stall");
  a_after_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wait_after_ms != 2'd3)
    else $error("bad wait after");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");
endmodule

bind char_lcd_command_sequencer clcd_checker u_clcd_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .bus_value, .wait_after_ms, .last
);
`default_nettype wire
